### rtl/core/lsg_pkg.sv
// Shared types and constants for the two-axis line step generator.
// No dependencies; every other file of the block imports this package.
package lsg_pkg;

  localparam int TARGET_W  = 16;
  localparam int SPM_W     = 10;
  localparam int LIMIT_W   = 16;
  localparam int OUT_POS_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 2;
  // Full product of a target and a steps-per-mm value.
  localparam int PROD_W    = TARGET_W + SPM_W;
  // Common width for range compares against any position width.
  localparam int WIDE_W    = 33;

  localparam logic OP_MOVE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPM_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPM_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_Y = 2'd3;

  localparam logic [SPM_W-1:0]   SPM_RESET   = 10'd80;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

  typedef struct packed {
    logic                operation;
    logic [TARGET_W-1:0] target_x_mm;
    logic [TARGET_W-1:0] target_y_mm;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 step_x;
    logic                 dir_x;
    logic                 step_y;
    logic                 dir_y;
    logic                 busy_res;
    logic                 line_done;
    logic                 motor_enable;
    logic [OUT_POS_W-1:0] position_x;
    logic [OUT_POS_W-1:0] position_y;
  } out_item_t;

  typedef struct packed {
    logic [SPM_W-1:0]   spm_x;
    logic [SPM_W-1:0]   spm_y;
    logic [LIMIT_W-1:0] limit_x;
    logic [LIMIT_W-1:0] limit_y;
  } cfg_t;

  // Item held in the input register: targets already converted to steps.
  typedef struct packed {
    logic              operation;
    logic [PROD_W-1:0] tx;
    logic [PROD_W-1:0] ty;
  } stg_item_t;

endpackage

### rtl/core/lsg_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on lsg_pkg for the payload types.
interface lsg_in_if;
  import lsg_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lsg_out_if;
  import lsg_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/lsg_in_stage.sv
// Input register of the line step generator; converts targets to steps on capture.
// Depends on lsg_pkg and lsg_if.
module lsg_in_stage #(
  parameter int MM_FRAC_BITS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  lsg_in_if.sink            in_chan,
  input  lsg_pkg::cfg_t     cfg,
  output logic              stg_valid,
  output lsg_pkg::stg_item_t stg_item,
  input  logic              stg_ready
);
  import lsg_pkg::*;

  logic              valid_r, valid_nxt;
  stg_item_t         item_r, item_nxt;
  logic [PROD_W-1:0] prod_x, prod_y;

  assign in_chan.ready = !valid_r || stg_ready;

  // Configuration must be kept stable by the user while items are in flight; this
  // stage does not enforce it and forms the product as the item is captured.
  always_comb begin
    prod_x             = PROD_W'(in_chan.data.target_x_mm) * PROD_W'(cfg.spm_x);
    prod_y             = PROD_W'(in_chan.data.target_y_mm) * PROD_W'(cfg.spm_y);
    item_nxt.operation = in_chan.data.operation;
    item_nxt.tx        = prod_x >> MM_FRAC_BITS;
    item_nxt.ty        = prod_y >> MM_FRAC_BITS;
    valid_nxt          = in_chan.ready ? in_chan.valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r <= item_nxt;
    end
  end

  assign stg_valid = valid_r;
  assign stg_item  = item_r;

endmodule

### rtl/core/lsg_core.sv
// Line state, Bresenham update and result register of the line step generator.
// Depends on lsg_pkg and lsg_if.
module lsg_core #(
  parameter int POS_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               stg_valid,
  input  lsg_pkg::stg_item_t stg_item,
  output logic               stg_ready,
  input  lsg_pkg::cfg_t      cfg,
  lsg_out_if.source          out_chan
);
  import lsg_pkg::*;

  localparam logic [WIDE_W-1:0] POS_MAX = (WIDE_W'(1) << POS_BITS) - WIDE_W'(1);

  logic [POS_BITS-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [POS_BITS-1:0] major_r, major_nxt, minor_r, minor_nxt;
  logic [POS_BITS-1:0] left_r, left_nxt;
  logic [POS_BITS:0]   err_r, err_nxt;
  logic                xmaj_r, xmaj_nxt, dirx_r, dirx_nxt, diry_r, diry_nxt;
  logic                active_r, active_nxt, awake_r, awake_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           res_r, res_nxt;

  logic                fire;
  logic [WIDE_W-1:0]   tx_w, ty_w, posx_w, posy_w;
  logic [POS_BITS-1:0] tx_p, ty_p, dx, dy;
  logic [POS_BITS:0]   acc_sum;
  logic                out_range, minor_step, sx, sy, done;
  logic [1:0]          status;

  assign stg_ready = !out_valid_r || out_chan.ready;
  assign fire      = stg_valid && stg_ready;

  always_comb begin
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    major_nxt  = major_r;
    minor_nxt  = minor_r;
    left_nxt   = left_r;
    err_nxt    = err_r;
    xmaj_nxt   = xmaj_r;
    dirx_nxt   = dirx_r;
    diry_nxt   = diry_r;
    active_nxt = active_r;
    awake_nxt  = awake_r;
    status     = ST_OK;
    sx         = 1'b0;
    sy         = 1'b0;
    done       = 1'b0;

    tx_w      = WIDE_W'(stg_item.tx);
    ty_w      = WIDE_W'(stg_item.ty);
    tx_p      = tx_w[POS_BITS-1:0];
    ty_p      = ty_w[POS_BITS-1:0];
    out_range = (tx_w > WIDE_W'(cfg.limit_x)) || (ty_w > WIDE_W'(cfg.limit_y)) ||
                (tx_w > POS_MAX) || (ty_w > POS_MAX);
    dx        = (pos_x_r > tx_p) ? (pos_x_r - tx_p) : (tx_p - pos_x_r);
    dy        = (pos_y_r > ty_p) ? (pos_y_r - ty_p) : (ty_p - pos_y_r);

    acc_sum    = err_r + {1'b0, minor_r};
    minor_step = (acc_sum >= {1'b0, major_r});

    if (stg_item.operation == OP_MOVE) begin
      priority if (active_r) begin
        status = ST_BUSY;
      end else if (out_range) begin
        status = ST_RANGE;
      end else begin
        awake_nxt  = 1'b1;
        dirx_nxt   = pos_x_r < tx_p;
        diry_nxt   = pos_y_r < ty_p;
        xmaj_nxt   = dx > dy;
        major_nxt  = (dx > dy) ? dx : dy;
        minor_nxt  = (dx > dy) ? dy : dx;
        err_nxt    = '0;
        left_nxt   = (dx > dy) ? dx : dy;
        active_nxt = ((dx > dy) ? dx : dy) != '0;
      end
    end else if (active_r) begin
      err_nxt = minor_step ? (acc_sum - {1'b0, major_r}) : acc_sum;
      sx      = xmaj_r ? 1'b1 : minor_step;
      sy      = xmaj_r ? minor_step : 1'b1;
      if (sx) begin
        pos_x_nxt = dirx_r ? (pos_x_r + 1'b1) : (pos_x_r - 1'b1);
      end
      if (sy) begin
        pos_y_nxt = diry_r ? (pos_y_r + 1'b1) : (pos_y_r - 1'b1);
      end
      left_nxt = left_r - 1'b1;
      if (left_r == POS_BITS'(1)) begin
        active_nxt = 1'b0;
        done       = 1'b1;
      end
    end

    posx_w               = WIDE_W'(pos_x_nxt);
    posy_w               = WIDE_W'(pos_y_nxt);
    res_nxt.status       = status;
    res_nxt.step_x       = sx;
    res_nxt.dir_x        = dirx_nxt;
    res_nxt.step_y       = sy;
    res_nxt.dir_y        = diry_nxt;
    res_nxt.busy_res     = active_nxt;
    res_nxt.line_done    = done;
    res_nxt.motor_enable = awake_nxt;
    res_nxt.position_x   = posx_w[OUT_POS_W-1:0];
    res_nxt.position_y   = posy_w[OUT_POS_W-1:0];

    out_valid_nxt = fire ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      major_r     <= '0;
      minor_r     <= '0;
      left_r      <= '0;
      err_r       <= '0;
      xmaj_r      <= 1'b0;
      dirx_r      <= 1'b0;
      diry_r      <= 1'b0;
      active_r    <= 1'b0;
      awake_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        pos_x_r  <= pos_x_nxt;
        pos_y_r  <= pos_y_nxt;
        major_r  <= major_nxt;
        minor_r  <= minor_nxt;
        left_r   <= left_nxt;
        err_r    <= err_nxt;
        xmaj_r   <= xmaj_nxt;
        dirx_r   <= dirx_nxt;
        diry_r   <= diry_nxt;
        active_r <= active_nxt;
        awake_r  <= awake_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = res_r;

endmodule

### rtl/core/two_axis_line_step_generator.sv
// Two-axis line step generator: top level with configuration registers.
// The input register captures each accepted item, then the result register holds its result.
// Throughput: one item per cycle while the result side takes results; the line update in
// lsg_core is combinational, and a stalled result side holds the input off once both registers are full.
// Reset (synchronous, rst_n low): idle, drivers asleep, position zero,
// steps per mm 80 on both axes, limits at their maximum.
module two_axis_line_step_generator #(
  parameter int POS_BITS     = 16,
  parameter int MM_FRAC_BITS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lsg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsg_pkg::CFG_DATA_W-1:0]   cfg_data,
  lsg_in_if.sink                           in_chan,
  lsg_out_if.source                        out_chan
);
  import lsg_pkg::*;

  // Configuration registers. The user must write them only while no item is in flight;
  // the block does not enforce it, and both stages read them without a guard.
  cfg_t      cfg_r, cfg_nxt;

  // Handshake between the input register and the line core.
  logic      stg_valid;
  logic      stg_ready;
  stg_item_t stg_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPM_X:   cfg_nxt.spm_x   = cfg_data[SPM_W-1:0];
        CFG_SPM_Y:   cfg_nxt.spm_y   = cfg_data[SPM_W-1:0];
        CFG_LIMIT_X: cfg_nxt.limit_x = cfg_data[LIMIT_W-1:0];
        CFG_LIMIT_Y: cfg_nxt.limit_y = cfg_data[LIMIT_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spm_x   <= SPM_RESET;
      cfg_r.spm_y   <= SPM_RESET;
      cfg_r.limit_x <= LIMIT_RESET;
      cfg_r.limit_y <= LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The input stage captures each item and turns its targets into step
  // counts with one multiply per axis, so the core sees only compares,
  // subtracts and the accumulator update.
  lsg_in_stage #(
    .MM_FRAC_BITS (MM_FRAC_BITS)
  ) u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg       (cfg_r),
    .stg_valid (stg_valid),
    .stg_item  (stg_item),
    .stg_ready (stg_ready)
  );

  // The core holds the line state and the result register. It takes the
  // next item whenever the result register is empty or being drained, so
  // moves and ticks can follow each other in every cycle.
  lsg_core #(
    .POS_BITS (POS_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .stg_valid (stg_valid),
    .stg_item  (stg_item),
    .stg_ready (stg_ready),
    .cfg       (cfg_r),
    .out_chan  (out_chan)
  );

endmodule

### sim/two_axis_line_step_generator_test.sv
// Self-checking testbench for the two-axis line step generator.
// Needs lsg_pkg and the lsg_in_if / lsg_out_if channel interfaces from the RTL.
// Drives move and tick items, predicts every report and checks it in order.
`timescale 1ns / 1ps

module two_axis_line_step_generator_test;
  import lsg_pkg::*;

  localparam int POS_W         = 16;
  localparam int FRAC_W        = 4;
  localparam logic [PROD_W-1:0] POS_MAX = PROD_W'((64'd1 << POS_W) - 1);
  // Longest line the random part starts on purpose, in steps.
  localparam int LONG_LINE     = 300;
  // Rough reach of a random move around the current position, in steps.
  localparam int NEAR_SPAN     = 40;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_SHOWN     = 10;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lsg_in_if  in_bus ();
  lsg_out_if out_bus ();

  two_axis_line_step_generator #(
    .POS_BITS    (POS_W),
    .MM_FRAC_BITS(FRAC_W)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // 20 ns clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stepper prediction. This is the testbench's own copy of the block's
  // registers and line state, advanced once per accepted item.
  // ---------------------------------------------------------------------------
  logic [SPM_W-1:0]   scale_x, scale_y;
  logic [LIMIT_W-1:0] bound_x, bound_y;
  logic [POS_W-1:0]   at_x, at_y;
  logic [POS_W-1:0]   long_dist, short_dist, ticks_left;
  logic [POS_W:0]     bres_err;
  logic               x_leads, fwd_x, fwd_y, line_on, drivers_on;

  // Expected reports, oldest first.
  out_item_t step_reports_q[$];

  int items_sent;
  int moves_taken, moves_range, moves_busy, lines_done, stepping_ticks;
  int settings_used;
  int mismatches;

  bit send_steady;   // sender offers items back to back
  bit sink_steady;   // receiver is always ready
  bit hold_pending;  // receiver should hold off for a long stretch

  task automatic clear_stepper();
    scale_x    = SPM_RESET;
    scale_y    = SPM_RESET;
    bound_x    = LIMIT_RESET;
    bound_y    = LIMIT_RESET;
    at_x       = '0;
    at_y       = '0;
    long_dist  = '0;
    short_dist = '0;
    ticks_left = '0;
    bres_err   = '0;
    x_leads    = 1'b0;
    fwd_x      = 1'b0;
    fwd_y      = 1'b0;
    line_on    = 1'b0;
    drivers_on = 1'b0;
  endtask

  // A target in 1/16 mm becomes floor(target * steps_per_mm / 16) steps.
  function automatic logic [PROD_W-1:0] to_steps(logic [TARGET_W-1:0] target,
                                                 logic [SPM_W-1:0] spm);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(target) * PROD_W'(spm);
    return prod >> FRAC_W;
  endfunction

  function automatic bit in_range(logic [PROD_W-1:0] tx, logic [PROD_W-1:0] ty);
    return tx <= PROD_W'(bound_x) && ty <= PROD_W'(bound_y) &&
           tx <= POS_MAX && ty <= POS_MAX;
  endfunction

  // Length in ticks of the line a move would start now; zero if rejected.
  function automatic int move_length(in_item_t it);
    logic [PROD_W-1:0] tx, ty;
    int dx, dy;
    tx = to_steps(it.target_x_mm, scale_x);
    ty = to_steps(it.target_y_mm, scale_y);
    if (!in_range(tx, ty)) return 0;
    dx = int'(tx) - int'(at_x);
    dy = int'(ty) - int'(at_y);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return (dx > dy) ? dx : dy;
  endfunction

  // Advances the stepper by one item and returns the report it must give.
  function automatic out_item_t predict_report(in_item_t it);
    out_item_t         rep;
    logic [PROD_W-1:0] tx, ty;
    logic [POS_W-1:0]  tgt_x, tgt_y, dx, dy;
    logic              minor_hit;
    rep = '0;
    minor_hit = 1'b0;
    if (it.operation == OP_MOVE) begin
      // A busy line wins over the range test.
      if (line_on) begin
        rep.status = ST_BUSY;
        moves_busy++;
      end else begin
        tx = to_steps(it.target_x_mm, scale_x);
        ty = to_steps(it.target_y_mm, scale_y);
        if (!in_range(tx, ty)) begin
          rep.status = ST_RANGE;
          moves_range++;
        end else begin
          tgt_x = tx[POS_W-1:0];
          tgt_y = ty[POS_W-1:0];
          dx = (tgt_x > at_x) ? tgt_x - at_x : at_x - tgt_x;
          dy = (tgt_y > at_y) ? tgt_y - at_y : at_y - tgt_y;
          drivers_on = 1'b1;
          // Direction is forward only for a strictly larger target.
          fwd_x      = at_x < tgt_x;
          fwd_y      = at_y < tgt_y;
          // On a tie Y leads.
          x_leads    = dx > dy;
          long_dist  = x_leads ? dx : dy;
          short_dist = x_leads ? dy : dx;
          bres_err   = '0;
          ticks_left = long_dist;
          line_on    = ticks_left != '0;
          moves_taken++;
        end
      end
    end else if (line_on) begin
      bres_err = bres_err + short_dist;
      if (bres_err >= {1'b0, long_dist}) begin
        bres_err  = bres_err - long_dist;
        minor_hit = 1'b1;
      end
      rep.step_x = x_leads ? 1'b1 : minor_hit;
      rep.step_y = x_leads ? minor_hit : 1'b1;
      if (rep.step_x) at_x = fwd_x ? at_x + 1'b1 : at_x - 1'b1;
      if (rep.step_y) at_y = fwd_y ? at_y + 1'b1 : at_y - 1'b1;
      ticks_left = ticks_left - 1'b1;
      stepping_ticks++;
      if (ticks_left == '0) begin
        line_on        = 1'b0;
        rep.line_done  = 1'b1;
        lines_done++;
      end
    end
    rep.dir_x        = fwd_x;
    rep.dir_y        = fwd_y;
    rep.busy_res     = line_on;
    rep.motor_enable = drivers_on;
    rep.position_x   = at_x;
    rep.position_y   = at_y;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Sending side. Every task here starts and ends at a falling edge, so the
  // valid line is assigned at most once per time step.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = send_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= it;
    do @(posedge clk); while (!in_bus.ready);
    // The item is taken at this edge, so the stepper advances now.
    step_reports_q.push_back(predict_report(it));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_op(input logic op, input logic [TARGET_W-1:0] tx,
                         input logic [TARGET_W-1:0] ty);
    in_item_t it;
    it.operation   = op;
    it.target_x_mm = tx;
    it.target_y_mm = ty;
    send_item(it);
  endtask

  // Ticks until the line in progress has issued its last step.
  task automatic finish_line();
    while (line_on) send_op(OP_TICK, 16'($urandom), 16'($urandom));
  endtask

  // Stops offering items and lets every outstanding report come back.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (step_reports_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register writes last one cycle; only issued while nothing is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SPM_X:   scale_x = value[SPM_W-1:0];
      CFG_SPM_Y:   scale_y = value[SPM_W-1:0];
      CFG_LIMIT_X: bound_x = value[LIMIT_W-1:0];
      CFG_LIMIT_Y: bound_y = value[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // The steps-per-mm registers are narrower than the write data; the spare
  // upper bits are filled at random and must be dropped by the block.
  task automatic apply_settings(input int spm_x, input int spm_y,
                                input int lim_x, input int lim_y);
    logic [CFG_DATA_W-1:0] junk;
    wait_drained();
    junk = CFG_DATA_W'($urandom) & ~CFG_DATA_W'((1 << SPM_W) - 1);
    write_reg(CFG_SPM_X, junk | CFG_DATA_W'(spm_x));
    junk = CFG_DATA_W'($urandom) & ~CFG_DATA_W'((1 << SPM_W) - 1);
    write_reg(CFG_SPM_Y, junk | CFG_DATA_W'(spm_y));
    write_reg(CFG_LIMIT_X, CFG_DATA_W'(lim_x));
    write_reg(CFG_LIMIT_Y, CFG_DATA_W'(lim_y));
    settings_used++;
  endtask

  // A target in 1/16 mm that lands a few dozen steps around a position.
  function automatic logic [TARGET_W-1:0] near_target(logic [POS_W-1:0] pos,
                                                      logic [SPM_W-1:0] spm);
    int base, reach, t;
    if (spm == '0) return TARGET_W'($urandom);
    base  = (int'(pos) << FRAC_W) / int'(spm);
    reach = (NEAR_SPAN << FRAC_W) / int'(spm);
    if (reach < 1) reach = 1;
    t = base + int'($urandom_range(0, 2 * reach)) - reach;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return TARGET_W'(t);
  endfunction

  // Mostly short lines around the current position; some moves go home or
  // carry fully random targets, which are usually out of range. Any pick
  // that would start a very long line falls back to a nearby target.
  task automatic pick_move(output in_item_t it);
    int r;
    it.operation = OP_MOVE;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      it.target_x_mm = near_target(at_x, scale_x);
      it.target_y_mm = near_target(at_y, scale_y);
    end else begin
      if (r < 85) begin
        it.target_x_mm = TARGET_W'($urandom);
        it.target_y_mm = TARGET_W'($urandom);
      end else begin
        it.target_x_mm = TARGET_W'($urandom_range(0, 3));
        it.target_y_mm = TARGET_W'($urandom_range(0, 3));
      end
      if (move_length(it) > LONG_LINE) begin
        it.target_x_mm = near_target(at_x, scale_x);
        it.target_y_mm = near_target(at_y, scale_y);
      end
    end
  endtask

  // Move, then tick the line out. While a line runs, a few moves with
  // random targets are thrown in and must come back as busy.
  task automatic run_random_lines(input int budget);
    in_item_t it;
    int       first;
    first = items_sent;
    while (items_sent - first < budget) begin
      pick_move(it);
      send_item(it);
      while (line_on) begin
        if ($urandom_range(0, 99) < 8) begin
          send_op(OP_MOVE, 16'($urandom), 16'($urandom));
        end else begin
          send_op(OP_TICK, 16'($urandom), 16'($urandom));
        end
      end
      if ($urandom_range(0, 3) == 0) send_op(OP_TICK, 16'($urandom), 16'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiving side: ready changes at falling edges only. Normally it stalls
  // for random stretches; on request it holds off for HOLD_CYCLES, counted
  // here, so the block fills up and stops taking items.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_pending = 1'b0;
        out_bus.ready <= 1'b1;
      end else if (sink_steady) begin
        out_bus.ready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          out_bus.ready <= 1'b1;
        end else begin
          out_bus.ready <= 1'b0;
          repeat (stall) @(negedge clk);
          out_bus.ready <= 1'b1;
        end
      end
    end
  end

  function automatic string show_report(out_item_t r);
    return $sformatf("st=%0d sx=%0b dx=%0b sy=%0b dy=%0b busy=%0b done=%0b en=%0b x=%0d y=%0d",
                     r.status, r.step_x, r.dir_x, r.step_y, r.dir_y, r.busy_res,
                     r.line_done, r.motor_enable, r.position_x, r.position_y);
  endfunction

  // Every report taken from the block is held against the oldest
  // expectation, one field at a time.
  always @(posedge clk) begin : report_check
    out_item_t want, got;
    string     bad;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = out_bus.data;
      if (step_reports_q.size() == 0) begin
        if (mismatches < MAX_SHOWN)
          $display("%0t: report with nothing expected: %s", $realtime, show_report(got));
        mismatches++;
      end else begin
        want = step_reports_q.pop_front();
        bad = "";
        if (got.status       !== want.status)       bad = {bad, " status"};
        if (got.step_x       !== want.step_x)       bad = {bad, " step_x"};
        if (got.dir_x        !== want.dir_x)        bad = {bad, " dir_x"};
        if (got.step_y       !== want.step_y)       bad = {bad, " step_y"};
        if (got.dir_y        !== want.dir_y)        bad = {bad, " dir_y"};
        if (got.busy_res     !== want.busy_res)     bad = {bad, " busy_res"};
        if (got.line_done    !== want.line_done)    bad = {bad, " line_done"};
        if (got.motor_enable !== want.motor_enable) bad = {bad, " motor_enable"};
        if (got.position_x   !== want.position_x)   bad = {bad, " position_x"};
        if (got.position_y   !== want.position_y)   bad = {bad, " position_y"};
        if (bad != "") begin
          if (mismatches < MAX_SHOWN) begin
            $display("%0t: mismatch in%s", $realtime, bad);
            $display("  expected %s", show_report(want));
            $display("  actual   %s", show_report(got));
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves an item for too long.
  int quiet_cycles;
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("[two_axis_line_step_generator] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset values: idle tick with drivers asleep, default scale of 80 steps/mm
  // makes the largest targets overflow, and a move to the origin is a
  // zero-length move that still wakes the drivers with both directions low.
  task automatic test_reset_state();
    send_op(OP_TICK, 16'hFFFF, 16'hFFFF);
    send_op(OP_MOVE, 16'hFFFF, 16'hFFFF);
    send_op(OP_MOVE, 16'h0000, 16'h0000);
    send_op(OP_TICK, 16'h0000, 16'h0000);
    wait_drained();
  endtask

  // With 16 steps/mm a target reads directly in steps. Limits are hit on
  // each axis, a target equal to its limit is taken, and a tied line runs
  // with Y leading. A move during the line, although also out of range,
  // must be refused as busy. The return trips cover an axis whose target
  // equals the position and lines that run backward.
  task automatic test_limits_and_lines();
    apply_settings(16, 16, 8, 3);
    send_op(OP_MOVE, 16'd9, 16'd0);
    send_op(OP_MOVE, 16'd0, 16'd4);
    send_op(OP_MOVE, 16'd3, 16'd3);
    send_op(OP_TICK, 16'd0, 16'd0);
    send_op(OP_MOVE, 16'hFFFF, 16'd0);
    finish_line();
    send_op(OP_TICK, 16'd0, 16'd0);
    send_op(OP_MOVE, 16'd3, 16'd1);
    finish_line();
    send_op(OP_MOVE, 16'd0, 16'd1);
    finish_line();
    wait_drained();
  endtask

  // A zero scale turns every target into the origin, and a zero limit only
  // admits the origin. The largest scale overflows the position width.
  task automatic test_degenerate_scales();
    apply_settings(0, 0, 0, 0);
    send_op(OP_MOVE, 16'hFFFF, 16'hFFFF);
    finish_line();
    apply_settings(1023, 1023, 65535, 65535);
    send_op(OP_MOVE, 16'hFFFF, 16'h0001);
    send_op(OP_MOVE, 16'h0001, 16'hFFFF);
    wait_drained();
  endtask

  // Random lines under several register settings, the extremes among them.
  task automatic test_random_settings();
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: apply_settings(80, 80, 65535, 65535);
        1: apply_settings(16, 16, $urandom_range(0, 65535), $urandom_range(0, 65535));
        2: apply_settings(1, 1023, 65535, 65535);
        3: apply_settings(1023, 1, $urandom_range(0, 2000), $urandom_range(0, 2000));
        4: apply_settings($urandom_range(1, 1023), $urandom_range(1, 1023),
                          $urandom_range(0, 65535), $urandom_range(0, 65535));
        default: apply_settings($urandom_range(1, 64), $urandom_range(1, 64), 65535, 65535);
      endcase
      run_random_lines(70);
    end
    wait_drained();
  endtask

  // The receiver holds off while the sender keeps offering items, so the
  // block has to stall its input. Afterwards the sender pauses until every
  // report has come back before a second burst.
  task automatic test_backpressure();
    apply_settings(16, 16, 65535, 65535);
    send_steady  = 1'b1;
    hold_pending = 1'b1;
    run_random_lines(60);
    send_steady = 1'b0;
    wait_drained();
    run_random_lines(30);
    wait_drained();
  endtask

  // Neither side idles: one item per cycle through the whole pipeline.
  task automatic test_full_rate();
    apply_settings(32, 24, 65535, 65535);
    send_steady = 1'b1;
    sink_steady = 1'b1;
    run_random_lines(100);
    send_steady = 1'b0;
    sink_steady = 1'b0;
    wait_drained();
  endtask

  initial begin : main_sequence
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_bus.valid   = 1'b0;
    in_bus.data    = '0;
    send_steady    = 1'b0;
    sink_steady    = 1'b0;
    hold_pending   = 1'b0;
    items_sent     = 0;
    moves_taken    = 0;
    moves_range    = 0;
    moves_busy     = 0;
    lines_done     = 0;
    stepping_ticks = 0;
    settings_used  = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    clear_stepper();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_limits_and_lines();
    test_degenerate_scales();
    test_random_settings();
    test_backpressure();
    test_full_rate();

    wait_drained();
    repeat (10) @(negedge clk);

    $display("Sent %0d items over %0d register settings: %0d moves taken, %0d out of range,",
             items_sent, settings_used, moves_taken, moves_range);
    $display("%0d refused as busy, %0d lines finished in %0d stepping ticks, %0d mismatches.",
             moves_busy, lines_done, stepping_ticks, mismatches);
    if (mismatches == 0 && step_reports_q.size() == 0) begin
      $display("[two_axis_line_step_generator] OK");
    end else begin
      if (step_reports_q.size() != 0)
        $display("%0d expected reports never arrived", step_reports_q.size());
      $display("[two_axis_line_step_generator] ERROR");
    end
    $finish;
  end

endmodule

### two_axis_line_step_generator.f
rtl/core/lsg_pkg.sv
rtl/core/lsg_if.sv
rtl/core/lsg_in_stage.sv
rtl/core/lsg_core.sv
rtl/core/two_axis_line_step_generator.sv
sim/two_axis_line_step_generator_test.sv
